### rtl/spdf_pkg.sv
// Shared types, widths and register codes for the spring-damper force block.
package spdf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned MUL_A_W = 64;
  localparam int unsigned MUL_B_W = 33;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_N_W = 65;
  localparam int unsigned DIV_D_W = 33;
  localparam int unsigned DIV_Q_W = 32;
  localparam int unsigned SQRT_N_W = 66;
  localparam int unsigned SQRT_R_W = 33;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [31:0] STIFF_RESET = 32'd0;
  localparam logic [31:0] REST_RESET = 32'd26214;
  localparam logic [31:0] BUMP_RESET = 32'd0;
  localparam logic [31:0] REBOUND_RESET = 32'd0;
  localparam logic [31:0] INV_DT_RESET = 32'd6553600;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAG_MAX = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFF   = 3'd0,
    REG_REST    = 3'd1,
    REG_BUMP    = 3'd2,
    REG_REBOUND = 3'd3,
    REG_INV_DT  = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_SPD,
    ST_SPR,
    ST_DMP,
    ST_FSUM,
    ST_FABS,
    ST_FCLIP,
    ST_FMUL,
    ST_FDIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [31:0] chassis_x;
    logic signed [31:0] chassis_y;
    logic signed [31:0] chassis_z;
    logic signed [31:0] arm_x;
    logic signed [31:0] arm_y;
    logic signed [31:0] arm_z;
  } spdf_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] force_scalar;
    logic [31:0]        spring_length;
    logic               zero_length;
    logic               saturated;
  } spdf_out_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

### rtl/spring_damper_force_step_core.sv
// Spring-damper strut force: sequencer, datapath registers and serial arithmetic units.
// Usage:
//   Input channel (in_valid_i, in_stall_o, in_data_i) takes one word with the
//   chassis and lower arm anchors. Output channel (out_valid_o, out_stall_i,
//   out_data_o) returns one result word per input word, in order.
//   Configuration registers are written through cfg_we_i, cfg_idx_i and
//   cfg_wdata_i; the user must write them only while the block is idle, as
//   the block itself does not enforce this; unknown indexes are ignored.
//   One word runs nine products on the bit-serial multiplier, a 33-step
//   square root and three 32-step divisions, plus sequencing states.
//   The next word is accepted once the previous result sits in the output
//   register, so a new word is not taken before the last one is through.
//   in_stall_o stays high while a word is in work.
//   When the receiver stalls, the result holds in the output register and a
//   following finished result waits in the sequencer until that slot frees.
//   Reset clears the sequencer, sets the registers to their defaults and the
//   stored previous length to the default rest length.
module spring_damper_force_step_core #(
  parameter int unsigned FRAC_BITS = spdf_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  spdf_pkg::spdf_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output spdf_pkg::spdf_out_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [spdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                     cfg_wdata_i
);
  import spdf_pkg::*;

  localparam int unsigned F2_W = 98;

  state_e state_q, state_d;
  logic   go_q, go_d;
  logic [1:0] ax_q, ax_d;

  logic [31:0] stiff_q, rest_q, bump_q, rebound_q, inv_dt_q, prev_q;

  logic [32:0] dmag_q [3];
  logic        dneg_q [3];
  logic [65:0] sum_q;
  logic [32:0] full_q;
  logic [31:0] x_q;
  logic [63:0] vmag_q;
  logic        vneg_q;
  logic [63:0] spr_q;
  logic        rneg_q;
  logic [95:0] dm_q;
  logic [F2_W-1:0] f2_q, t_q;
  logic        fneg_q;
  logic [31:0] fmag_q, fs_q;
  logic        sneg_q;
  logic [31:0] fv_q [3];
  logic        sat_q;

  spdf_out_t out_q;
  logic      out_valid_q, out_free;

  unit_ctl_t mul_ctl, div_ctl, sqrt_ctl;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic [DIV_Q_W-1:0]  div_q;
  logic [SQRT_R_W-1:0] root;

  logic [31:0] chs [3];
  logic [31:0] arm [3];
  logic [32:0] diff [3];
  logic [31:0] spd_mag, rst_mag;
  logic [63:0] vmag_w;
  logic [F2_W-1:0] f2_a, f2_b, f2_abs;
  logic [1:0]  f2_cin;
  logic        t_neg, t_big_neg, t_big_pos;
  logic [31:0] fmag_w;
  logic        q_neg;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    chs[0] = in_data_i.chassis_x;
    chs[1] = in_data_i.chassis_y;
    chs[2] = in_data_i.chassis_z;
    arm[0] = in_data_i.arm_x;
    arm[1] = in_data_i.arm_y;
    arm[2] = in_data_i.arm_z;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {chs[i][31], chs[i]} - {arm[i][31], arm[i]};
    end
  end

  always_comb begin
    spd_mag = (x_q < prev_q) ? prev_q - x_q : x_q - prev_q;
    rst_mag = (rest_q >= x_q) ? rest_q - x_q : x_q - rest_q;
    vmag_w = mul_p[63:0] >> FRAC_BITS;
    f2_a = rneg_q ? ~{34'b0, spr_q} : {34'b0, spr_q};
    f2_b = vneg_q ? {2'b0, dm_q} : ~{2'b0, dm_q};
    f2_cin = {1'b0, rneg_q} + {1'b0, !vneg_q};
    f2_abs = f2_q[F2_W-1] ? ~f2_q + 1'b1 : f2_q;
    t_neg = fneg_q && (t_q != '0);
    t_big_neg = (t_q[F2_W-1:32] != '0) || (t_q[31:0] > NEG_MAG_MAX);
    t_big_pos = (t_q[F2_W-1:32] != '0) || (t_q[31:0] > POS_MAX);
    if (t_neg) fmag_w = t_big_neg ? NEG_MAG_MAX : t_q[31:0];
    else       fmag_w = t_big_pos ? POS_MAX : t_q[31:0];
    q_neg = (sneg_q != dneg_q[ax_q]) && (div_q != '0);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = {31'b0, dmag_q[ax_q]};
        mul_b = dmag_q[ax_q];
      end
      ST_SPD: begin
        mul_a = {32'b0, spd_mag};
        mul_b = {1'b0, inv_dt_q};
      end
      ST_SPR: begin
        mul_a = {32'b0, rst_mag};
        mul_b = {1'b0, stiff_q};
      end
      ST_DMP: begin
        mul_a = vmag_q;
        mul_b = {1'b0, vneg_q ? bump_q : rebound_q};
      end
      ST_FMUL: begin
        mul_a = {31'b0, dmag_q[ax_q]};
        mul_b = {1'b0, fmag_q};
      end
      default: ;
    endcase
  end

  assign mul_ctl.start = go_q && (state_q == ST_SQ || state_q == ST_SPD ||
                                  state_q == ST_SPR || state_q == ST_DMP ||
                                  state_q == ST_FMUL);
  assign sqrt_ctl.start = go_q && (state_q == ST_ROOT);
  assign div_ctl.start = go_q && (state_q == ST_FDIV);

  spdf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_ctl.start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_ctl.done),
    .p_o     (mul_p)
  );

  spdf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_ctl.start),
    .n_i     (sum_q),
    .done_o  (sqrt_ctl.done),
    .root_o  (root)
  );

  spdf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_ctl.start),
    .n_i     (mul_p[DIV_N_W-1:0]),
    .d_i     (full_q),
    .done_o  (div_ctl.done),
    .q_o     (div_q)
  );

  always_comb begin
    state_d = state_q;
    go_d = 1'b0;
    ax_d = ax_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SQ;
          go_d = 1'b1;
          ax_d = '0;
        end
      end
      ST_SQ: begin
        if (mul_ctl.done) begin
          go_d = 1'b1;
          if (ax_q == 2'd2) state_d = ST_ROOT;
          else ax_d = ax_q + 1'b1;
        end
      end
      ST_ROOT: begin
        if (sqrt_ctl.done) begin
          state_d = ST_SPD;
          go_d = 1'b1;
        end
      end
      ST_SPD: begin
        if (mul_ctl.done) begin
          state_d = ST_SPR;
          go_d = 1'b1;
        end
      end
      ST_SPR: begin
        if (mul_ctl.done) begin
          state_d = ST_DMP;
          go_d = 1'b1;
        end
      end
      ST_DMP: begin
        if (mul_ctl.done) state_d = ST_FSUM;
      end
      ST_FSUM: state_d = ST_FABS;
      ST_FABS: state_d = ST_FCLIP;
      ST_FCLIP: begin
        state_d = ST_FMUL;
        go_d = 1'b1;
        ax_d = '0;
      end
      ST_FMUL: begin
        if (mul_ctl.done) begin
          state_d = ST_FDIV;
          go_d = 1'b1;
        end
      end
      ST_FDIV: begin
        if (div_ctl.done) begin
          if (ax_q == 2'd2) begin
            state_d = ST_DONE;
          end else begin
            ax_d = ax_q + 1'b1;
            state_d = ST_FMUL;
            go_d = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      ax_q        <= '0;
      out_valid_q <= 1'b0;
      prev_q      <= REST_RESET;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      ax_q    <= ax_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        prev_q      <= x_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q   <= STIFF_RESET;
      rest_q    <= REST_RESET;
      bump_q    <= BUMP_RESET;
      rebound_q <= REBOUND_RESET;
      inv_dt_q  <= INV_DT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STIFF:   stiff_q   <= cfg_wdata_i;
        REG_REST:    rest_q    <= cfg_wdata_i;
        REG_BUMP:    bump_q    <= cfg_wdata_i;
        REG_REBOUND: rebound_q <= cfg_wdata_i;
        REG_INV_DT:  inv_dt_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          for (int i = 0; i < 3; i++) begin
            dneg_q[i] <= diff[i][32];
            dmag_q[i] <= diff[i][32] ? 33'd0 - diff[i] : diff[i];
          end
          sum_q <= '0;
          sat_q <= 1'b0;
        end
      end
      ST_SQ: begin
        if (mul_ctl.done) sum_q <= sum_q + mul_p[65:0];
      end
      ST_ROOT: begin
        if (sqrt_ctl.done) begin
          full_q <= root;
          x_q    <= root[32] ? '1 : root[31:0];
          if (root[32]) sat_q <= 1'b1;
        end
      end
      ST_SPD: begin
        if (mul_ctl.done) begin
          vmag_q <= vmag_w;
          vneg_q <= (x_q < prev_q) && (vmag_w != '0);
        end
      end
      ST_SPR: begin
        if (mul_ctl.done) begin
          spr_q  <= mul_p[63:0];
          rneg_q <= rest_q < x_q;
        end
      end
      ST_DMP: begin
        if (mul_ctl.done) dm_q <= mul_p[95:0];
      end
      ST_FSUM: f2_q <= f2_a + f2_b + {96'b0, f2_cin};
      ST_FABS: begin
        fneg_q <= f2_q[F2_W-1];
        t_q    <= f2_abs >> FRAC_BITS;
      end
      ST_FCLIP: begin
        fmag_q <= fmag_w;
        sneg_q <= t_neg;
        fs_q   <= t_neg ? 32'd0 - fmag_w : fmag_w;
        if (t_neg ? t_big_neg : t_big_pos) sat_q <= 1'b1;
      end
      ST_FDIV: begin
        if (div_ctl.done) begin
          if (full_q == '0) begin
            fv_q[ax_q] <= '0;
          end else if (q_neg) begin
            fv_q[ax_q] <= 32'd0 - div_q;
          end else if (div_q > POS_MAX) begin
            fv_q[ax_q] <= POS_MAX;
            sat_q <= 1'b1;
          end else begin
            fv_q[ax_q] <= div_q;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_q.force_x       <= fv_q[0];
          out_q.force_y       <= fv_q[1];
          out_q.force_z       <= fv_q[2];
          out_q.force_scalar  <= fs_q;
          out_q.spring_length <= x_q;
          out_q.zero_length   <= full_q == '0;
          out_q.saturated     <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("word accepted but sequencer not busy");

  a_zero_len_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_length |->
      out_data_o.force_x == '0 && out_data_o.force_y == '0 &&
      out_data_o.force_z == '0)
    else $error("zero length with nonzero force vector");

  a_one_unit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({mul_ctl.start, sqrt_ctl.start, div_ctl.start}) <= 1)
    else $error("two arithmetic units started together");

  a_load_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && out_stall_i |=> state_q == ST_DONE)
    else $error("result left sequencer while output slot was full");
`endif

endmodule

### rtl/spdf_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module spdf_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [spdf_pkg::MUL_A_W-1:0]  a_i,
  input  logic [spdf_pkg::MUL_B_W-1:0]  b_i,
  output logic                          done_o,
  output logic [spdf_pkg::MUL_P_W-1:0]  p_o
);
  import spdf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_B_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

  logic [MUL_A_W-1:0] a_q, hi_q, hi_d;
  logic [MUL_B_W-1:0] lo_q, lo_d;
  logic [MUL_A_W:0]   s;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;

  always_comb begin
    s = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    hi_d = s[MUL_A_W:1];
    lo_d = {s[0], lo_q[MUL_B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign p_o = {hi_q, lo_q};

endmodule

### rtl/spdf_div.sv
// Restoring divider, one quotient bit per cycle.
module spdf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [spdf_pkg::DIV_N_W-1:0]  n_i,
  input  logic [spdf_pkg::DIV_D_W-1:0]  d_i,
  output logic                          done_o,
  output logic [spdf_pkg::DIV_Q_W-1:0]  q_o
);
  import spdf_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_Q_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_Q_W - 1);

  logic [DIV_D_W-1:0] rem_q, rem_d, d_q;
  logic [DIV_Q_W-1:0] q_q;
  logic [DIV_D_W:0]   t, diff;
  logic               ge;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;

  always_comb begin
    t = {rem_q, q_q[DIV_Q_W-1]};
    diff = t - {1'b0, d_q};
    ge = t >= {1'b0, d_q};
    rem_d = ge ? diff[DIV_D_W-1:0] : t[DIV_D_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= n_i[DIV_N_W-1:DIV_Q_W];
      q_q   <= n_i[DIV_Q_W-1:0];
      d_q   <= d_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      q_q   <= {q_q[DIV_Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign q_o = q_q;

endmodule

### rtl/spdf_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module spdf_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [spdf_pkg::SQRT_N_W-1:0]  n_i,
  output logic                           done_o,
  output logic [spdf_pkg::SQRT_R_W-1:0]  root_o
);
  import spdf_pkg::*;

  localparam int unsigned STEPS = SQRT_N_W / 2;
  localparam int unsigned REM_W = SQRT_R_W + 2;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [SQRT_N_W-1:0] n_q;
  logic [SQRT_R_W-1:0] root_q;
  logic [REM_W-1:0]    rem_q;
  logic [REM_W+1:0]    r2, trial, diff;
  logic                ge;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q, done_q;

  always_comb begin
    r2 = {rem_q, n_q[SQRT_N_W-1:SQRT_N_W-2]};
    trial = {2'b00, root_q, 2'b01};
    diff = r2 - trial;
    ge = r2 >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= n_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= {n_q[SQRT_N_W-3:0], 2'b00};
      rem_q  <= ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
      root_q <= {root_q[SQRT_R_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### bench/tb_spring_damper_force_step_core.sv
// Testbench for the spring-damper strut force block: directed and random anchors against a predictor.
module tb_spring_damper_force_step_core;
  import spdf_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned LATENCY = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  spdf_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  spdf_out_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  logic [31:0] stiffness, rest_len, damp_bump, damp_rebound, inv_dt, prev_len;
  spdf_out_t   expected_forces[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          stall_mode = 0;
  int          gap_max = 0;
  bit          hold_go = 0;
  int          hold_cnt = 0;

  spring_damper_force_step_core dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] clip_s32(input logic neg, input logic [127:0] m,
                                           inout logic sat);
    if (neg) begin
      if (m > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(128'd0 - m);
    end
    if (m > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return m[31:0];
  endfunction

  function automatic spdf_out_t predict_force(spdf_in_t w);
    logic signed [63:0] a[3], b[3], d[3];
    logic [127:0] dm[3];
    logic dn[3];
    logic [127:0] sum, r, c, x, mag, vmag, damp, t, fmag, q;
    logic signed [127:0] f2, fsv;
    logic vneg, fneg, sat, sneg, n;
    logic [31:0] fs;
    spdf_out_t o;
    a[0] = w.chassis_x; a[1] = w.chassis_y; a[2] = w.chassis_z;
    b[0] = w.arm_x; b[1] = w.arm_y; b[2] = w.arm_z;
    sum = 0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i] = a[i] - b[i];
      dn[i] = d[i] < 0;
      dm[i] = dn[i] ? 128'(-d[i]) : 128'(d[i]);
      sum += dm[i] * dm[i];
    end
    r = 0;
    for (int k = 40; k >= 0; k--) begin
      c = r | (128'd1 << k);
      if (c * c <= sum) r = c;
    end
    if (r > 128'hFFFF_FFFF) begin
      x = 128'hFFFF_FFFF;
      sat = 1'b1;
    end else begin
      x = r;
    end
    vneg = x < prev_len;
    mag = vneg ? prev_len - x : x - prev_len;
    vmag = (mag * inv_dt) >> FB;
    if (vmag == 0) vneg = 1'b0;
    damp = vneg ? damp_bump : damp_rebound;
    mag = (rest_len >= x) ? rest_len - x : x - rest_len;
    f2 = mag * stiffness;
    if (rest_len < x) f2 = -f2;
    f2 = vneg ? f2 + vmag * damp : f2 - vmag * damp;
    fneg = f2[127];
    t = fneg ? 128'(-f2) : 128'(f2);
    t = t >> FB;
    if (t == 0) fneg = 1'b0;
    fs = clip_s32(fneg, t, sat);
    fsv = $signed(fs);
    sneg = fs[31];
    fmag = sneg ? 128'(-fsv) : 128'(fsv);
    o.force_x = '0; o.force_y = '0; o.force_z = '0;
    for (int i = 0; i < 3; i++) begin
      if (r != 0) begin
        q = (fmag * dm[i]) / r;
        n = (sneg != dn[i]) && q != 0;
        case (i)
          0: o.force_x = clip_s32(n, q, sat);
          1: o.force_y = clip_s32(n, q, sat);
          default: o.force_z = clip_s32(n, q, sat);
        endcase
      end
    end
    o.force_scalar = fs;
    o.spring_length = x[31:0];
    o.zero_length = (r == 0);
    o.saturated = sat;
    prev_len = x[31:0];
    return o;
  endfunction

  task automatic send_word(spdf_in_t w);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_forces.push_back(predict_force(w));
    gap = (gap_max > 0 && $urandom_range(0, 2) == 0) ? $urandom_range(1, gap_max) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_STIFF:   stiffness = v;
      REG_REST:    rest_len = v;
      REG_BUMP:    damp_bump = v;
      REG_REBOUND: damp_rebound = v;
      REG_INV_DT:  inv_dt = v;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] k, logic [31:0] rl, logic [31:0] bmp,
                          logic [31:0] reb, logic [31:0] idt);
    write_reg(REG_STIFF, k);
    write_reg(REG_REST, rl);
    write_reg(REG_BUMP, bmp);
    write_reg(REG_REBOUND, reb);
    write_reg(REG_INV_DT, idt);
  endtask

  function automatic spdf_in_t anchors(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                       logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
    spdf_in_t w;
    w.chassis_x = cx; w.chassis_y = cy; w.chassis_z = cz;
    w.arm_x = ax; w.arm_y = ay; w.arm_z = az;
    return w;
  endfunction

  function automatic spdf_in_t rand_strut(int sz);
    spdf_in_t w;
    w.chassis_x = $urandom(); w.chassis_y = $urandom(); w.chassis_z = $urandom();
    case ($urandom_range(0, 9))
      0: begin
        w.arm_x = $urandom(); w.arm_y = $urandom(); w.arm_z = $urandom();
      end
      1: begin
        w.arm_x = w.chassis_x; w.arm_y = w.chassis_y; w.arm_z = w.chassis_z;
      end
      default: begin
        w.arm_x = w.chassis_x + $signed($urandom_range(0, 2 * sz)) - sz;
        w.arm_y = w.chassis_y + $signed($urandom_range(0, 2 * sz)) - sz;
        w.arm_z = w.chassis_z + $signed($urandom_range(0, 2 * sz)) - sz;
      end
    endcase
    return w;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        stall_mode = $urandom_range(0, 2);
        gap_max = $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
      end
      send_word(rand_strut($urandom_range(0, 1) ? 32'h0001_0000 : 32'h00FF_FFFF));
    end
    drain();
  endtask

  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    stall_mode = 1;
    gap_max = 3;
    set_regs(32'h0010_0000, 32'h0000_6666, 32'h0002_0000, 32'h0003_0000, 32'h0064_0000);
    send_word(anchors(0, 0, 0, 0, 0, 0));
    send_word(anchors(mx, mx, mx, mn, mn, mn));
    send_word(anchors(mn, mn, mn, mx, mx, mx));
    send_word(anchors(mx, 0, 0, mn, 0, 0));
    send_word(anchors(0, mn, 0, 0, mx, 0));
    send_word(anchors(32'h0001_0000, 0, 0, 0, 0, 0));
    send_word(anchors(0, 0, 32'h0000_4000, 0, 0, 0));
    send_word(anchors(0, 0, 0, 0, 0, 32'h0000_8000));
    send_word(anchors(-1, -1, -1, 0, 0, 0));
    send_word(anchors(32'h0000_6666, 0, 0, 0, 0, 0));
    drain();
    write_reg(REG_INV_DT, 32'd0);
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    send_word(anchors(0, 32'h0002_0000, 0, 0, 0, 0));
    send_word(anchors(0, 32'h0000_1000, 0, 0, 0, 0));
    drain();
    set_regs('1, '1, '1, '1, '1);
    send_word(anchors(0, 0, 0, 0, 0, 0));
    send_word(anchors(mx, mx, mx, mn, mn, mn));
    send_word(anchors(32'h0000_0100, 0, 0, 0, 0, 0));
    send_word(anchors(mx, mn, mx, mn, mx, mn));
    drain();
    write_reg(REG_REST, 32'd0);
    write_reg(REG_INV_DT, 32'd1);
    send_word(anchors(0, 0, 0, 0, 0, 0));
    send_word(anchors(mx, 0, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_backpressure();
    stall_mode = 0;
    gap_max = 0;
    hold_go = 1'b1;
    for (int i = 0; i < 8; i++) send_word(rand_strut(32'h0001_0000));
    drain();
    gap_max = 10;
    for (int i = 0; i < 6; i++) send_word(rand_strut(32'h0001_0000));
    drain();
  endtask

  task automatic test_random_settings();
    set_regs(32'h0100_0000, 32'h0000_6666, 32'h0008_0000, 32'h0010_0000, 32'h003C_0000);
    run_random(250);
    set_regs(0, 0, 0, 0, 1);
    run_random(150);
    set_regs('1, '1, '1, '1, '1);
    run_random(200);
    for (int p = 0; p < 4; p++) begin
      set_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(1, 32'hFFFF_FFFF));
      run_random(210);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_go && hold_cnt == 0) begin
      hold_go <= 1'b0;
      hold_cnt <= 3000;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= (hold_cnt > 1);
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        default: out_stall_i <= ($urandom_range(0, 99) < 5) ? ~out_stall_i : out_stall_i;
      endcase
    end
  end

  always @(posedge clk_i) begin
    spdf_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_forces.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_forces.pop_front();
        if (out_data_o.force_x !== e.force_x) begin
          $error("force_x exp %0d got %0d", e.force_x, out_data_o.force_x); errors++;
        end
        if (out_data_o.force_y !== e.force_y) begin
          $error("force_y exp %0d got %0d", e.force_y, out_data_o.force_y); errors++;
        end
        if (out_data_o.force_z !== e.force_z) begin
          $error("force_z exp %0d got %0d", e.force_z, out_data_o.force_z); errors++;
        end
        if (out_data_o.force_scalar !== e.force_scalar) begin
          $error("force_scalar exp %0d got %0d", e.force_scalar, out_data_o.force_scalar);
          errors++;
        end
        if (out_data_o.spring_length !== e.spring_length) begin
          $error("spring_length exp %0h got %0h", e.spring_length, out_data_o.spring_length);
          errors++;
        end
        if (out_data_o.zero_length !== e.zero_length) begin
          $error("zero_length exp %0b got %0b", e.zero_length, out_data_o.zero_length);
          errors++;
        end
        if (out_data_o.saturated !== e.saturated) begin
          $error("saturated exp %0b got %0b", e.saturated, out_data_o.saturated); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stiffness = STIFF_RESET;
    rest_len = REST_RESET;
    damp_bump = BUMP_RESET;
    damp_rebound = REBOUND_RESET;
    inv_dt = INV_DT_RESET;
    prev_len = REST_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_word(anchors(0, 32'h0000_6000, 0, 0, 0, 0));
    drain();
    test_directed();
    test_backpressure();
    test_random_settings();
    drain();
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0 && expected_forces.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/spdf_pkg.sv
rtl/spdf_mul.sv
rtl/spdf_div.sv
rtl/spdf_sqrt.sv
rtl/spring_damper_force_step_core.sv
bench/tb_spring_damper_force_step_core.sv
